### hw/rtl/tnwq_pkg.sv
// Shared types and constants for the ticket notify wait queue.
// No dependencies; every other file except tnwq_ram imports this package.
package tnwq_pkg;

  localparam int QDEPTH    = 16;
  localparam int TID_W     = 8;
  localparam int TKT_W     = 32;
  localparam int PORT_TID_W = 8;
  localparam int IDX_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int LEN_W     = $clog2(QDEPTH + 1);
  localparam int ENT_W     = TID_W + TKT_W;
  localparam int CMDQ_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_TAKE       = 2'd0,
    ACT_WAIT       = 2'd1,
    ACT_NOTIFY_ONE = 2'd2,
    ACT_NOTIFY_ALL = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_ISSUED     = 3'd0,
    KIND_ALREADY    = 3'd1,
    KIND_PARKED     = 3'd2,
    KIND_FULL       = 3'd3,
    KIND_READY      = 3'd4,
    KIND_NOTHING    = 3'd5,
    KIND_NOT_QUEUED = 3'd6
  } kind_t;

  // Work handed from the front to the back
  typedef enum logic [1:0] {
    CMD_EMIT   = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_DRAIN  = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    kind_t             kind;
    logic [TID_W-1:0]  thread;
    logic [TKT_W-1:0]  ticket;
  } cmd_t;

  typedef struct packed {
    logic             busy;
    logic [LEN_W-1:0] len;
  } back_status_t;

endpackage

### hw/rtl/ticket_notify_wait_queue_top.sv
// Ticket notify wait queue: a request is accepted when start is high and
// busy is low, and results appear one per cycle on out_valid, which the
// receiver cannot hold off. take_ticket, wait, any notify that finds the
// counters equal and any notify that finds the queue empty give a single
// result without the back half leaving its idle state. notify_one scans the
// parked entries one per cycle through the entry RAM's single read port and
// then compacts the tail behind the hit one entry per cycle; scan and
// compaction together visit each parked entry once, whether or not the
// entry is found. notify_all gives one result per parked entry on
// consecutive cycles.
// Depends on tnwq_pkg, tnwq_front, tnwq_cmd_fifo, tnwq_back, tnwq_ram.
module ticket_notify_wait_queue_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_thread_id,
  input  logic [31:0] in_ticket,
  output logic        out_valid,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_thread_id_out,
  output logic [31:0] out_ticket_out,
  output logic        out_last
);
  import tnwq_pkg::*;

  logic         push;
  cmd_t         push_cmd;
  logic         pop;
  logic         fifo_not_empty;
  cmd_t         fifo_head;
  back_status_t back_status;

  tnwq_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_action     (in_action),
    .in_thread_id  (in_thread_id),
    .in_ticket     (in_ticket),
    .fifo_not_empty(fifo_not_empty),
    .back_status   (back_status),
    .busy          (busy),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  tnwq_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .not_empty(fifo_not_empty),
    .head     (fifo_head)
  );

  tnwq_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (fifo_not_empty),
    .cmd              (fifo_head),
    .pop              (pop),
    .status           (back_status),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_thread_id_out(out_thread_id_out),
    .out_ticket_out   (out_ticket_out),
    .out_last         (out_last)
  );

  // An accepted request keeps the block busy in the following cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // A result that is not the last of its request is followed by another
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("result burst broke before its last result");

  // A parked result always leaves at least one entry in the queue
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_PARKED) |-> (back_status.len != '0))
    else $error("parked result with empty queue");

  // Nothing new is accepted while a result burst is still running
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("not busy during a result burst");

endmodule

### hw/rtl/tnwq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tnwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/tnwq_cmd_fifo.sv
// Short command queue between the front and back halves.
// Depends on tnwq_pkg for cmd_t and the queue depth.
module tnwq_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tnwq_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          not_empty,
  output tnwq_pkg::cmd_t head
);
  import tnwq_pkg::*;

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             slot_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == CMDQ_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == CMDQ_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold request payloads
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

endmodule

### hw/rtl/tnwq_front.sv
// Front half: accepts requests, owns the ticket counters, classifies each
// request into a back-end command. Depends on tnwq_pkg.
module tnwq_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [1:0]               in_action,
  input  logic [7:0]               in_thread_id,
  input  logic [31:0]              in_ticket,
  input  logic                     fifo_not_empty,
  input  tnwq_pkg::back_status_t   back_status,
  output logic                     busy,
  output logic                     push,
  output tnwq_pkg::cmd_t           push_cmd
);
  import tnwq_pkg::*;

  logic [TKT_W-1:0] wait_cnt_r, wait_cnt_nxt;
  logic [TKT_W-1:0] notify_cnt_r, notify_cnt_nxt;
  logic [TKT_W-1:0] tkt_diff;
  logic             tkt_old;
  logic             cnt_equal;

  // Stay busy while any request is queued or in work
  assign busy = fifo_not_empty || back_status.busy;
  assign push = start && !busy;

  assign tkt_diff  = in_ticket - notify_cnt_r;
  assign tkt_old   = tkt_diff[TKT_W-1];
  assign cnt_equal = (wait_cnt_r == notify_cnt_r);

  // Classify the request
  always_comb begin
    wait_cnt_nxt    = wait_cnt_r;
    notify_cnt_nxt  = notify_cnt_r;
    push_cmd.op     = CMD_EMIT;
    push_cmd.kind   = KIND_NOTHING;
    push_cmd.thread = in_thread_id[TID_W-1:0];
    push_cmd.ticket = '0;
    unique case (action_t'(in_action))
      ACT_TAKE: begin
        push_cmd.kind   = KIND_ISSUED;
        push_cmd.ticket = wait_cnt_r;
        wait_cnt_nxt    = wait_cnt_r + 1'b1;
      end
      ACT_WAIT: begin
        if (tkt_old) begin
          push_cmd.kind = KIND_ALREADY;
        end else if (32'(back_status.len) >= QDEPTH) begin
          push_cmd.kind = KIND_FULL;
        end else begin
          push_cmd.op     = CMD_APPEND;
          push_cmd.kind   = KIND_PARKED;
          push_cmd.ticket = in_ticket;
        end
      end
      ACT_NOTIFY_ONE: begin
        if (!cnt_equal) begin
          notify_cnt_nxt  = notify_cnt_r + 1'b1;
          push_cmd.ticket = notify_cnt_r;
          if (back_status.len == '0) begin
            push_cmd.kind   = KIND_NOT_QUEUED;
            push_cmd.ticket = '0;
          end else begin
            push_cmd.op   = CMD_FIND;
            push_cmd.kind = KIND_READY;
          end
        end
      end
      ACT_NOTIFY_ALL: begin
        if (!cnt_equal) begin
          notify_cnt_nxt = wait_cnt_r;
          if (back_status.len == '0) begin
            push_cmd.kind = KIND_NOT_QUEUED;
          end else begin
            push_cmd.op   = CMD_DRAIN;
            push_cmd.kind = KIND_READY;
          end
        end
      end
      default: begin
        push_cmd.kind = KIND_NOTHING;
      end
    endcase
  end

  // Update counters on accept only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_cnt_r   <= '0;
      notify_cnt_r <= '0;
    end else if (push) begin
      wait_cnt_r   <= wait_cnt_nxt;
      notify_cnt_r <= notify_cnt_nxt;
    end
  end

endmodule

### hw/rtl/tnwq_back.sv
// Back half: owns the parked-entry RAM and its length; appends, scans,
// compacts and drains entries, and drives the result register.
// Depends on tnwq_pkg and tnwq_ram.
module tnwq_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  input  tnwq_pkg::cmd_t         cmd,
  output logic                   pop,
  output tnwq_pkg::back_status_t status,
  output logic                   out_valid,
  output logic [2:0]             out_kind,
  output logic [7:0]             out_thread_id_out,
  output logic [31:0]            out_ticket_out,
  output logic                   out_last
);
  import tnwq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [TKT_W-1:0] target_r, target_nxt;

  logic             out_valid_r, out_valid_nxt;
  kind_t            out_kind_r, out_kind_nxt;
  logic [TID_W-1:0] out_thread_r, out_thread_nxt;
  logic [TKT_W-1:0] out_ticket_r, out_ticket_nxt;
  logic             out_last_r, out_last_nxt;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;
  logic [TID_W-1:0] rd_thread;
  logic [TKT_W-1:0] rd_ticket;

  logic [LEN_W:0]   idx_p1, idx_p2, len_ext;
  logic             hit;

  assign {rd_thread, rd_ticket} = ram_rdata;
  assign len_ext = {1'b0, len_r};
  assign idx_p1  = (LEN_W + 1)'(idx_r) + 1'b1;
  assign idx_p2  = (LEN_W + 1)'(idx_r) + 2'd2;
  assign hit     = (rd_ticket == target_r);

  tnwq_ram #(
    .WIDTH(ENT_W),
    .DEPTH(QDEPTH)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Sequence each command; the read address always runs one entry ahead
  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    target_nxt     = target_r;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_thread_nxt = '0;
    out_ticket_nxt = '0;
    out_last_nxt   = 1'b1;
    ram_we         = 1'b0;
    ram_waddr      = len_r[IDX_W-1:0];
    ram_wdata      = {cmd.thread, cmd.ticket};
    ram_re         = 1'b0;
    ram_raddr      = '0;
    pop            = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          pop = 1'b1;
          unique case (cmd.op)
            CMD_EMIT: begin
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = cmd.kind;
              out_ticket_nxt = cmd.ticket;
            end
            CMD_APPEND: begin
              ram_we        = 1'b1;
              len_nxt       = len_r + 1'b1;
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_PARKED;
            end
            CMD_FIND: begin
              target_nxt = cmd.ticket;
              ram_re     = 1'b1;
              idx_nxt    = '0;
              state_nxt  = S_SCAN;
            end
            CMD_DRAIN: begin
              ram_re    = 1'b1;
              idx_nxt   = '0;
              state_nxt = S_DRAIN;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        ram_raddr = idx_p1[IDX_W-1:0];
        ram_re    = (idx_p1 < len_ext);
        if (hit) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_READY;
          out_thread_nxt = rd_thread;
          out_ticket_nxt = target_r;
          if (idx_p1 < len_ext) begin
            state_nxt = S_SHIFT;
          end else begin
            len_nxt   = len_r - 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (idx_p1 == len_ext) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_NOT_QUEUED;
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SHIFT: begin
        // Close the gap: entry k+1 moves to k
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        ram_raddr = idx_p2[IDX_W-1:0];
        if (idx_p2 < len_ext) begin
          ram_re  = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end else begin
          len_nxt   = len_r - 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DRAIN: begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = KIND_READY;
        out_thread_nxt = rd_thread;
        out_ticket_nxt = rd_ticket;
        out_last_nxt   = (idx_p1 == len_ext);
        ram_raddr      = idx_p1[IDX_W-1:0];
        if (idx_p1 == len_ext) begin
          len_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          ram_re  = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    target_r     <= target_nxt;
    out_kind_r   <= out_kind_nxt;
    out_thread_r <= out_thread_nxt;
    out_ticket_r <= out_ticket_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign status.busy       = (state_r != S_IDLE);
  assign status.len        = len_r;
  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_thread_id_out = PORT_TID_W'(out_thread_r);
  assign out_ticket_out    = out_ticket_r;
  assign out_last          = out_last_r;

endmodule

### verif/tb_ticket_notify_wait_queue_top.sv
// Self-checking testbench for ticket_notify_wait_queue_top: drives take, wait and notify
// requests and checks every result against a cycle-free model of the ticket queue.
// Depends on tnwq_pkg and the RTL of ticket_notify_wait_queue_top.
`timescale 1ns / 1ps

module tb_ticket_notify_wait_queue_top;
  import tnwq_pkg::*;

  localparam int RANDOM_REQS = 410;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    action_t     act;
    logic [7:0]  tid;
    logic [31:0] tkt;
  } ticket_req_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  tid;
    logic [31:0] tkt;
    logic        last;
  } queue_outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_action = ACT_TAKE;
  logic [7:0]  in_thread_id = '0;
  logic [31:0] in_ticket = '0;
  logic        out_valid;
  logic [2:0]  out_kind;
  logic [7:0]  out_thread_id_out;
  logic [31:0] out_ticket_out;
  logic        out_last;

  // Requests waiting to be driven, and the results they are predicted to give
  ticket_req_t    req_q[$];
  queue_outcome_t outcome_q[$];

  // Model state of the wait queue
  logic [31:0]      wait_ctr;
  logic [31:0]      notify_ctr;
  int               park_len;
  logic [31:0]      park_tkt[QDEPTH];
  logic [TID_W-1:0] park_tid[QDEPTH];

  // Generator view of the wait counter, used to build well-formed waits
  logic [31:0] gen_wait_ctr;

  ticket_req_t cur_req;
  int          gap_left;
  int          run_left;
  bit          run_gappy;
  int          reqs_total;
  int          reqs_accepted;
  int          results_checked;
  int          fail_cnt;
  int          stall_cycles;
  int          kind_seen[8];

  ticket_notify_wait_queue_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_thread_id      (in_thread_id),
    .in_ticket         (in_ticket),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_thread_id_out (out_thread_id_out),
    .out_ticket_out    (out_ticket_out),
    .out_last          (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic push_outcome(input kind_t kind, input logic [7:0] tid,
                              input logic [31:0] tkt, input logic last);
    queue_outcome_t o;
    o.kind = kind;
    o.tid  = tid;
    o.tkt  = tkt;
    o.last = last;
    outcome_q.push_back(o);
  endtask

  // Apply one accepted request to the model and queue the results it gives
  task automatic predict_request(input ticket_req_t r);
    logic [31:0]      diff;
    logic [31:0]      target;
    logic [TID_W-1:0] tid;
    int               len;
    int               hit;
    len = park_len;
    tid = r.tid[TID_W-1:0];
    case (r.act)
      ACT_TAKE: begin
        push_outcome(KIND_ISSUED, '0, wait_ctr, 1'b1);
        wait_ctr = wait_ctr + 1;
      end
      ACT_WAIT: begin
        // Ticket order wraps: a precedes b when a - b is negative
        diff = r.tkt - notify_ctr;
        if (diff[31]) begin
          push_outcome(KIND_ALREADY, '0, '0, 1'b1);
        end else if (len >= QDEPTH) begin
          push_outcome(KIND_FULL, '0, '0, 1'b1);
        end else begin
          park_tkt[len] = r.tkt;
          park_tid[len] = tid;
          park_len = len + 1;
          push_outcome(KIND_PARKED, '0, '0, 1'b1);
        end
      end
      default: begin
        if (wait_ctr == notify_ctr) begin
          push_outcome(KIND_NOTHING, '0, '0, 1'b1);
        end else if (r.act == ACT_NOTIFY_ONE) begin
          target = notify_ctr;
          notify_ctr = target + 1;
          hit = -1;
          for (int i = 0; i < len; i++) begin
            if (hit < 0 && park_tkt[i] == target) hit = i;
          end
          if (hit < 0) begin
            push_outcome(KIND_NOT_QUEUED, '0, '0, 1'b1);
          end else begin
            push_outcome(KIND_READY, 8'(park_tid[hit]), target, 1'b1);
            // Close the gap behind the readied entry
            for (int j = hit; j + 1 < len; j++) begin
              park_tkt[j] = park_tkt[j + 1];
              park_tid[j] = park_tid[j + 1];
            end
            park_len = len - 1;
          end
        end else begin
          notify_ctr = wait_ctr;
          park_len = 0;
          if (len == 0) begin
            push_outcome(KIND_NOT_QUEUED, '0, '0, 1'b1);
          end else begin
            for (int i = 0; i < len; i++) begin
              push_outcome(KIND_READY, 8'(park_tid[i]), park_tkt[i], i + 1 == len);
            end
          end
        end
      end
    endcase
  endtask

  task automatic add_req(input action_t act, input logic [7:0] tid, input logic [31:0] tkt);
    ticket_req_t r;
    r.act = act;
    r.tid = tid;
    r.tkt = tkt;
    req_q.push_back(r);
    reqs_total++;
    if (act == ACT_TAKE) gen_wait_ctr = gen_wait_ctr + 1;
  endtask

  // Stimulus, end of run and final verdict
  initial begin
    int          sel;
    int          n;
    int          goal;
    logic [31:0] t;
    wait_ctr      = '0;
    notify_ctr    = '0;
    park_len      = 0;
    gen_wait_ctr  = '0;
    reqs_total    = 0;

    // Directed: equal counters, wrap-around compare, absent entry, duplicates
    add_req(ACT_NOTIFY_ONE, 8'h00, 32'h0);
    add_req(ACT_NOTIFY_ALL, 8'h00, 32'h0);
    add_req(ACT_WAIT, 8'hFF, 32'h0000_0000);
    add_req(ACT_TAKE, 8'h00, 32'h0);
    add_req(ACT_WAIT, 8'h00, 32'hFFFF_FFFF);
    add_req(ACT_WAIT, 8'h5A, 32'h7FFF_FFFF);
    add_req(ACT_WAIT, 8'h01, 32'h8000_0000);
    add_req(ACT_NOTIFY_ONE, 8'h00, 32'h0);
    add_req(ACT_NOTIFY_ONE, 8'h00, 32'h0);
    add_req(ACT_TAKE, 8'h00, 32'h0);
    add_req(ACT_TAKE, 8'h00, 32'h0);
    add_req(ACT_NOTIFY_ONE, 8'h00, 32'h0);
    add_req(ACT_WAIT, 8'h33, 32'h0000_0001);
    add_req(ACT_NOTIFY_ALL, 8'h00, 32'h0);
    add_req(ACT_NOTIFY_ALL, 8'h00, 32'h0);
    add_req(ACT_TAKE, 8'h00, 32'h0);
    add_req(ACT_NOTIFY_ALL, 8'h00, 32'h0);
    add_req(ACT_TAKE, 8'h00, 32'h0);
    add_req(ACT_WAIT, 8'h11, 32'h0000_0004);
    add_req(ACT_WAIT, 8'h22, 32'h0000_0004);
    add_req(ACT_NOTIFY_ONE, 8'h00, 32'h0);
    add_req(ACT_NOTIFY_ALL, 8'h00, 32'h0);
    add_req(ACT_TAKE, 8'h00, 32'h0);
    add_req(ACT_NOTIFY_ALL, 8'h00, 32'h0);

    // Fill the queue past its depth, then drain it
    goal = RANDOM_REQS;
    add_req(ACT_TAKE, 8'h00, 32'h0);
    for (int i = 0; i < QDEPTH + 2; i++) begin
      add_req(ACT_WAIT, 8'($urandom_range(0, 255)), gen_wait_ctr + $urandom_range(0, 40));
    end
    add_req(ACT_NOTIFY_ALL, 8'h00, 32'h0);

    // Random mix, led by take-then-wait pairs, with notifies in between
    while (reqs_total < goal) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        t = gen_wait_ctr;
        add_req(ACT_TAKE, 8'($urandom), 32'($urandom));
        add_req(ACT_WAIT, 8'($urandom_range(0, 255)), t);
      end else if (sel < 50) begin
        add_req(ACT_TAKE, 8'($urandom), 32'($urandom));
      end else if (sel < 65) begin
        add_req(ACT_NOTIFY_ONE, 8'($urandom), 32'($urandom));
      end else if (sel < 72) begin
        add_req(ACT_NOTIFY_ALL, 8'($urandom), 32'($urandom));
      end else if (sel < 80) begin
        add_req(ACT_WAIT, 8'($urandom_range(0, 255)), gen_wait_ctr - $urandom_range(0, 8));
      end else if (sel < 86) begin
        case ($urandom_range(0, 3))
          0: t = gen_wait_ctr + 32'h7FFF_FFFF;
          1: t = gen_wait_ctr + 32'h8000_0000;
          2: t = 32'hFFFF_FFFF;
          default: t = 32'h0;
        endcase
        add_req(ACT_WAIT, 8'($urandom_range(0, 255)), t);
      end else if (sel < 90) begin
        n = $urandom_range(4, 12);
        for (int i = 0; i < n; i++) begin
          add_req(ACT_WAIT, 8'($urandom_range(0, 255)), gen_wait_ctr + $urandom_range(0, 24));
        end
      end else begin
        add_req(action_t'($urandom_range(0, 3)), 8'($urandom), 32'($urandom));
      end
    end

    // Hold reset, then let the driver run
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (reqs_accepted != reqs_total) @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests, checked %0d results, %0d failures.",
             reqs_accepted, results_checked, fail_cnt);
    $display("Seen: issued %0d, already %0d, parked %0d, full %0d, ready %0d, nothing %0d, absent %0d",
             kind_seen[KIND_ISSUED], kind_seen[KIND_ALREADY], kind_seen[KIND_PARKED],
             kind_seen[KIND_FULL], kind_seen[KIND_READY], kind_seen[KIND_NOTHING],
             kind_seen[KIND_NOT_QUEUED]);
    if (fail_cnt == 0 && outcome_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Drive requests: predict on accept, then present the next after a random gap
  always @(posedge clk) begin
    if (!rst_n) begin
      start         <= 1'b0;
      in_action     <= ACT_TAKE;
      in_thread_id  <= '0;
      in_ticket     <= '0;
      gap_left      <= 0;
      run_left      = 0;
      run_gappy     = 1'b0;
      reqs_accepted = 0;
    end else begin
      if (start && !busy) begin
        predict_request(cur_req);
        reqs_accepted++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          in_action    <= cur_req.act;
          in_thread_id <= cur_req.tid;
          in_ticket    <= cur_req.tkt;
          start        <= 1'b1;
          // Alternate stretches of back-to-back requests and gappy ones
          if (run_left == 0) begin
            run_left  = $urandom_range(8, 40);
            run_gappy = $urandom_range(0, 1);
          end
          run_left--;
          gap_left <= run_gappy ? $urandom_range(0, 16) : 0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Check each result strobe against the oldest prediction
  always @(posedge clk) begin
    queue_outcome_t exp_o;
    if (rst_n && out_valid) begin
      if (out_kind < 3'd7) kind_seen[out_kind]++;
      if (outcome_q.size() == 0) begin
        if (fail_cnt < MAX_REPORTS)
          $display("Unexpected result: kind %0d thread %h ticket %h last %0d",
                   out_kind, out_thread_id_out, out_ticket_out, out_last);
        fail_cnt++;
      end else begin
        exp_o = outcome_q.pop_front();
        results_checked++;
        if (out_kind !== exp_o.kind || out_thread_id_out !== exp_o.tid ||
            out_ticket_out !== exp_o.tkt || out_last !== exp_o.last) begin
          if (fail_cnt < MAX_REPORTS)
            $display("Mismatch: kind %0d/%0d thread %h/%h ticket %h/%h last %0d/%0d (exp/got)",
                     exp_o.kind, out_kind, exp_o.tid, out_thread_id_out,
                     exp_o.tkt, out_ticket_out, exp_o.last, out_last);
          fail_cnt++;
        end
      end
    end
  end

  // Abort when neither side moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no request or result for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
